### hdl/rgb_calibrate_and_classify_macros.svh
// Assertion macros used by the checker of the colour classifier.
// Each one samples on clk and is switched off while arst_n is low.
`ifndef RGB_CALIBRATE_AND_CLASSIFY_MACROS_SVH
`define RGB_CALIBRATE_AND_CLASSIFY_MACROS_SVH

// Check that a condition implies another in the same cycle
`define RCC_ASSERT_IMPLIES(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("rcc check failed");

// Check that a condition implies another in the following cycle
`define RCC_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("rcc check failed");

`endif

### hdl/rcc_pkg.sv
`default_nettype none
package rcc_pkg;

	// Field widths
	localparam int RAW_W     = 20;
	localparam int FRAC_W    = 16;
	localparam int LEVEL_W   = FRAC_W + 1;
	localparam int CLASS_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int LANES     = 3;

	// Lane order inside the packed arrays
	localparam int LANE_RED   = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE  = 2;

	// From an accepted item to its done strobe lie one set-up stage,
	// one cell per quotient bit and one classification stage
	localparam int LATENCY = FRAC_W + 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_RED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_GREEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_BLUE  = 3'd5;

	localparam logic [RAW_W-1:0] BLACK_RESET = '0;
	localparam logic [RAW_W-1:0] WHITE_RESET = RAW_W'(1);

	// Levels in unsigned 1.16 fixed point
	localparam logic [LEVEL_W-1:0] FULL_SCALE  = LEVEL_W'(65536);
	localparam logic [LEVEL_W-1:0] TH_RED_BLUE = LEVEL_W'(13107);
	localparam logic [LEVEL_W-1:0] TH_GREEN    = LEVEL_W'(3277);
	localparam logic [LEVEL_W-1:0] TH_WHITE    = LEVEL_W'(22938);
	localparam logic [LEVEL_W-1:0] TH_BLACK    = LEVEL_W'(6554);

	typedef enum logic [CLASS_W-1:0] {
		CLS_UNKNOWN = 3'd0,
		CLS_RED     = 3'd1,
		CLS_GREEN   = 3'd2,
		CLS_BLUE    = 3'd3,
		CLS_WHITE   = 3'd4,
		CLS_BLACK   = 3'd5
	} colour_class_t;

	// How a lane's level is formed at the end of the chain
	typedef enum logic [1:0] {
		MODE_DIV  = 2'd0,
		MODE_ZERO = 2'd1,
		MODE_FULL = 2'd2
	} lvl_mode_t;

	// Per-channel division state handed from cell to cell
	typedef struct packed {
		lvl_mode_t          mode;
		logic [RAW_W-1:0]   rem;
		logic [RAW_W-1:0]   dvs;
		logic [FRAC_W-1:0]  quo;
	} lane_t;

	typedef struct packed {
		logic                vld;
		lane_t [LANES-1:0]   lane;
	} stage_t;

endpackage
`default_nettype wire

### hdl/rcc_prep_stage.sv
`default_nettype none
module rcc_prep_stage import rcc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [LANES-1:0][RAW_W-1:0]  raw,
	input  logic [LANES-1:0][RAW_W-1:0]  black,
	input  logic [LANES-1:0][RAW_W-1:0]  white,
	output stage_t                       prep_s1
);

	lane_t [LANES-1:0] lane_c;
	lane_t [LANES-1:0] lane_s1;
	logic              vld_s1;

	// Sort out the special cases and form remainder and divisor
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_c[i].quo = '0;
			if (white[i] <= black[i] || raw[i] <= black[i]) begin
				lane_c[i].mode = MODE_ZERO;
				lane_c[i].rem  = '0;
				lane_c[i].dvs  = RAW_W'(1);
			end else if (raw[i] >= white[i]) begin
				lane_c[i].mode = MODE_FULL;
				lane_c[i].rem  = '0;
				lane_c[i].dvs  = RAW_W'(1);
			end else begin
				lane_c[i].mode = MODE_DIV;
				lane_c[i].rem  = raw[i] - black[i];
				lane_c[i].dvs  = white[i] - black[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	// Load the payload only for an accepted item
	always_ff @(posedge clk) begin
		if (take) begin
			lane_s1 <= lane_c;
		end
	end

	assign prep_s1.vld  = vld_s1;
	assign prep_s1.lane = lane_s1;

endmodule
`default_nettype wire

### hdl/rcc_div_cell.sv
`default_nettype none
module rcc_div_cell import rcc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t stage_in,
	output stage_t stage_out
);

	logic [LANES-1:0][RAW_W:0] shifted_c;
	logic [LANES-1:0]          ge_c;
	lane_t [LANES-1:0]         lane_c;
	lane_t [LANES-1:0]         lane_q;
	logic                      vld_q;

	// Develop one quotient bit per lane: shift, compare, subtract
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_c[i]    = stage_in.lane[i];
			shifted_c[i] = {stage_in.lane[i].rem, 1'b0};
			ge_c[i]      = shifted_c[i] >= {1'b0, stage_in.lane[i].dvs};
			if (ge_c[i]) begin
				lane_c[i].rem = RAW_W'(shifted_c[i] - {1'b0, stage_in.lane[i].dvs});
			end else begin
				lane_c[i].rem = RAW_W'(shifted_c[i]);
			end
			lane_c[i].quo = {stage_in.lane[i].quo[FRAC_W-2:0], ge_c[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= stage_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_in.vld) begin
			lane_q <= lane_c;
		end
	end

	assign stage_out.vld  = vld_q;
	assign stage_out.lane = lane_q;

endmodule
`default_nettype wire

### hdl/rcc_classify.sv
`default_nettype none
module rcc_classify import rcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stage_t               stage_in,
	output logic                 done,
	output logic [CLASS_W-1:0]   colour_class,
	output logic [LEVEL_W-1:0]   level_red,
	output logic [LEVEL_W-1:0]   level_green,
	output logic [LEVEL_W-1:0]   level_blue
);

	logic [LANES-1:0][LEVEL_W-1:0] lvl_c;
	logic [LANES-1:0][LEVEL_W-1:0] lvl_q;
	colour_class_t                 cls_c;
	colour_class_t                 cls_q;
	logic                          done_q;
	logic [LEVEL_W-1:0]            r_c;
	logic [LEVEL_W-1:0]            g_c;
	logic [LEVEL_W-1:0]            b_c;

	// Apply saturation to each quotient
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			unique case (stage_in.lane[i].mode)
				MODE_DIV:  lvl_c[i] = {1'b0, stage_in.lane[i].quo};
				MODE_FULL: lvl_c[i] = FULL_SCALE;
				MODE_ZERO: lvl_c[i] = '0;
				default:   lvl_c[i] = '0;
			endcase
		end
	end

	assign r_c = lvl_c[LANE_RED];
	assign g_c = lvl_c[LANE_GREEN];
	assign b_c = lvl_c[LANE_BLUE];

	// Classify in priority order
	always_comb begin
		priority if (r_c > g_c && r_c > b_c && r_c > TH_RED_BLUE) begin
			cls_c = CLS_RED;
		end else if (g_c > r_c && g_c > b_c && g_c > TH_GREEN) begin
			cls_c = CLS_GREEN;
		end else if (b_c > r_c && b_c > g_c && b_c > TH_RED_BLUE) begin
			cls_c = CLS_BLUE;
		end else if (r_c > TH_WHITE && g_c > TH_WHITE && b_c > TH_WHITE) begin
			cls_c = CLS_WHITE;
		end else if (r_c < TH_BLACK && g_c < TH_BLACK && b_c < TH_BLACK) begin
			cls_c = CLS_BLACK;
		end else begin
			cls_c = CLS_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stage_in.vld;
		end
	end

	// Register the result with its strobe; it holds until the next item
	always_ff @(posedge clk) begin
		if (stage_in.vld) begin
			lvl_q <= lvl_c;
			cls_q <= cls_c;
		end
	end

	assign done         = done_q;
	assign colour_class = cls_q;
	assign level_red    = lvl_q[LANE_RED];
	assign level_green  = lvl_q[LANE_GREEN];
	assign level_blue   = lvl_q[LANE_BLUE];

endmodule
`default_nettype wire

### hdl/rgb_calibrate_and_classify.sv
`default_nettype none
// Two-point calibrated colour classifier. Each red, green, blue triple is
// scaled as (raw - black) / (white - black) into 1.16 fixed point, clamped
// to 0..65536, and sorted into red, green, blue, white, black or unknown.
// A new item is taken on any cycle with start high; busy never rises, so
// one item per clock is sustained. Every item gives one result, marked by
// done for a single cycle; between the item and its result lie the set-up
// stage, a chain of 16 divider cells (one quotient bit each, all three
// channels side by side) and the classification stage. The receiver
// cannot stall the result, so it must take done when it comes.
// The calibration registers are written through cfg_valid/cfg_ready
// (ready is always high) and should only change while no item is in the
// chain. Indexes 6 and 7 are ignored.
module rgb_calibrate_and_classify import rcc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [RAW_W-1:0]       raw_red,
	input  logic [RAW_W-1:0]       raw_green,
	input  logic [RAW_W-1:0]       raw_blue,
	output logic                   done,
	output logic [CLASS_W-1:0]     colour_class,
	output logic [LEVEL_W-1:0]     level_red,
	output logic [LEVEL_W-1:0]     level_green,
	output logic [LEVEL_W-1:0]     level_blue,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [RAW_W-1:0]       cfg_data
);

	logic [LANES-1:0][RAW_W-1:0] black_q;
	logic [LANES-1:0][RAW_W-1:0] white_q;
	logic [LANES-1:0][RAW_W-1:0] raw_c;
	logic                        take;
	stage_t                      chain [0:FRAC_W];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	assign raw_c[LANE_RED]   = raw_red;
	assign raw_c[LANE_GREEN] = raw_green;
	assign raw_c[LANE_BLUE]  = raw_blue;

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				black_q[i] <= BLACK_RESET;
				white_q[i] <= WHITE_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLACK_RED:   black_q[LANE_RED]   <= cfg_data;
				REG_BLACK_GREEN: black_q[LANE_GREEN] <= cfg_data;
				REG_BLACK_BLUE:  black_q[LANE_BLUE]  <= cfg_data;
				REG_WHITE_RED:   white_q[LANE_RED]   <= cfg_data;
				REG_WHITE_GREEN: white_q[LANE_GREEN] <= cfg_data;
				REG_WHITE_BLUE:  white_q[LANE_BLUE]  <= cfg_data;
				default: ;
			endcase
		end
	end

	rcc_prep_stage u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.raw     (raw_c),
		.black   (black_q),
		.white   (white_q),
		.prep_s1 (chain[0])
	);

	// One cell per quotient bit, most significant first
	for (genvar k = 0; k < FRAC_W; k++) begin : g_cell
		rcc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (chain[k]),
			.stage_out (chain[k+1])
		);
	end

	rcc_classify u_classify (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_in     (chain[FRAC_W]),
		.done         (done),
		.colour_class (colour_class),
		.level_red    (level_red),
		.level_green  (level_green),
		.level_blue   (level_blue)
	);

endmodule
`default_nettype wire

### hdl/rcc_checker.sv
`default_nettype none
`include "rgb_calibrate_and_classify_macros.svh"
module rcc_checker import rcc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [CLASS_W-1:0]     colour_class,
	input logic [LEVEL_W-1:0]     level_red,
	input logic [LEVEL_W-1:0]     level_green,
	input logic [LEVEL_W-1:0]     level_blue
);

	logic levels_ok;
	logic red_ok;
	logic white_ok;

	assign levels_ok = level_red <= FULL_SCALE && level_green <= FULL_SCALE &&
		level_blue <= FULL_SCALE;
	assign red_ok    = level_red > level_green && level_red > level_blue &&
		level_red > TH_RED_BLUE;
	assign white_ok  = level_red > TH_WHITE && level_green > TH_WHITE &&
		level_blue > TH_WHITE;

	// Every result traces back to an item taken a fixed time earlier
	`RCC_ASSERT_IMPLIES(a_done_has_item, done, $past(start && !busy, LATENCY))

	// Every item taken is reported a fixed time later
	`RCC_ASSERT_NEXT(a_item_gives_done, start && !busy, ##(LATENCY-1) done)

	// Levels never exceed full scale
	`RCC_ASSERT_IMPLIES(a_level_range, done, levels_ok)

	// A red verdict needs a strict red maximum above its threshold
	`RCC_ASSERT_IMPLIES(a_red_max, done && colour_class == CLS_RED, red_ok)

	// A white verdict needs every level above the white threshold
	`RCC_ASSERT_IMPLIES(a_white_all, done && colour_class == CLS_WHITE, white_ok)

endmodule

bind rgb_calibrate_and_classify rcc_checker u_rcc_checker (.*);
`default_nettype wire
